/* src/bol_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_pkg: shared definitions for the bounded ordered list
// Sizes, operation and status codes, the per-item edit decision and the
// helper that widens a stored word to the reported field width.
// ----------------------------------------------------------------------------
package bol_pkg;

  // Storage sizes.
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Fixed widths of the channel fields.
  localparam int OP_W  = 3;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_OUT_W = 5;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AFTER = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    EK_NONE = 2'd0,
    EK_INS  = 2'd1,
    EK_DEL  = 2'd2
  } edit_kind_t;

  // Edit broadcast to every cell of the chain.
  typedef struct packed {
    edit_kind_t kind;
    idx_t       idx;
  } edit_t;

  // Decision for one item.
  typedef struct packed {
    status_t status;
    edit_t   edit;
    cnt_t    len_nxt;
  } ctrl_t;

  // Sign-extend a stored word and keep the low bits of the reported field.
  function automatic logic [VAL_W-1:0] report_word(input word_t w);
    logic signed [63:0] wide;
    wide = 64'(signed'(w));
    return wide[VAL_W-1:0];
  endfunction

endpackage

/* src/bol_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_in_if / bol_out_if: valid-ready channels of the bounded ordered list
// One beat moves one edit request in, or one result out.
// ----------------------------------------------------------------------------
interface bol_in_if;
  logic                        valid;
  logic                        ready;
  logic [bol_pkg::OP_W-1:0]    op;
  logic [bol_pkg::POS_W-1:0]   position;
  logic signed [bol_pkg::VAL_W-1:0] value;

  modport source (output valid, op, position, value, input ready);
  modport sink   (input valid, op, position, value, output ready);
endinterface

interface bol_out_if;
  logic                             valid;
  logic                             ready;
  logic [bol_pkg::ST_W-1:0]         status;
  logic signed [bol_pkg::VAL_W-1:0] removed_value;
  logic signed [bol_pkg::VAL_W-1:0] front_value;
  logic signed [bol_pkg::VAL_W-1:0] back_value;
  logic [bol_pkg::CNT_OUT_W-1:0]    count;

  modport source (output valid, status, removed_value, front_value, back_value, count,
                  input ready);
  modport sink   (input valid, status, removed_value, front_value, back_value, count,
                  output ready);
endinterface

/* src/bol_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_cell: one storage cell of the list chain
// Holds one word and, on an edit, keeps it, loads the new word, or takes the
// word of its left or right neighbor.
// ----------------------------------------------------------------------------
module bol_cell (
  input  logic                 clk,
  input  logic                 edit_en,
  input  bol_pkg::edit_t       edit,
  input  bol_pkg::idx_t        cell_idx,
  input  bol_pkg::word_t       new_word,
  input  bol_pkg::word_t       left_word,
  input  bol_pkg::word_t       right_word,
  output bol_pkg::word_t       word
);

  bol_pkg::word_t word_r;
  bol_pkg::word_t word_nxt;

  // Insert opens a gap at the edit index; delete closes the gap there.
  always_comb begin
    word_nxt = word_r;
    if (edit_en) begin
      unique case (edit.kind)
        bol_pkg::EK_INS: begin
          if (cell_idx > edit.idx) begin
            word_nxt = left_word;
          end else if (cell_idx == edit.idx) begin
            word_nxt = new_word;
          end
        end
        bol_pkg::EK_DEL: begin
          if (cell_idx >= edit.idx) begin
            word_nxt = right_word;
          end
        end
        default: word_nxt = word_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

/* src/bol_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_ctrl: edit decoder of the bounded ordered list
// Checks an operation against the current length and picks the status, the
// edit for the cell chain and the new length.
// ----------------------------------------------------------------------------
module bol_ctrl (
  input  logic [bol_pkg::OP_W-1:0]  op,
  input  logic [bol_pkg::POS_W-1:0] position,
  input  bol_pkg::cnt_t             length,
  output bol_pkg::ctrl_t            ctrl
);

  logic          is_full;
  logic          is_empty;
  logic          pos_bad;
  bol_pkg::cnt_t len_inc;
  bol_pkg::cnt_t len_dec;

  assign is_full  = (int'(length) >= bol_pkg::CAPACITY);
  assign is_empty = (length == '0);
  assign pos_bad  = (position == '0) || (int'(position) > int'(length));
  assign len_inc  = length + 1'b1;
  assign len_dec  = length - 1'b1;

  always_comb begin
    ctrl.status    = bol_pkg::ST_OK;
    ctrl.edit.kind = bol_pkg::EK_NONE;
    ctrl.edit.idx  = '0;
    ctrl.len_nxt   = length;
    unique case (op) inside
      bol_pkg::OP_INS_FRONT, bol_pkg::OP_INS_BACK, bol_pkg::OP_INS_AFTER: begin
        if (is_full) begin
          ctrl.status = bol_pkg::ST_FULL;
        end else if (is_empty) begin
          // Any insert into an empty list makes its only element.
          ctrl.edit.kind = bol_pkg::EK_INS;
          ctrl.len_nxt   = len_inc;
        end else if (op == bol_pkg::OP_INS_FRONT) begin
          ctrl.edit.kind = bol_pkg::EK_INS;
          ctrl.len_nxt   = len_inc;
        end else if (op == bol_pkg::OP_INS_BACK) begin
          ctrl.edit.kind = bol_pkg::EK_INS;
          ctrl.edit.idx  = bol_pkg::IDX_W'(length);
          ctrl.len_nxt   = len_inc;
        end else if (pos_bad) begin
          ctrl.status = bol_pkg::ST_BADPOS;
        end else begin
          ctrl.edit.kind = bol_pkg::EK_INS;
          ctrl.edit.idx  = bol_pkg::IDX_W'(position);
          ctrl.len_nxt   = len_inc;
        end
      end
      bol_pkg::OP_DEL_FRONT, bol_pkg::OP_DEL_BACK, bol_pkg::OP_DEL_AT: begin
        if (is_empty) begin
          ctrl.status = bol_pkg::ST_EMPTY;
        end else if (op == bol_pkg::OP_DEL_FRONT) begin
          ctrl.edit.kind = bol_pkg::EK_DEL;
          ctrl.len_nxt   = len_dec;
        end else if (op == bol_pkg::OP_DEL_BACK) begin
          ctrl.edit.kind = bol_pkg::EK_DEL;
          ctrl.edit.idx  = bol_pkg::IDX_W'(len_dec);
          ctrl.len_nxt   = len_dec;
        end else if (pos_bad) begin
          ctrl.status = bol_pkg::ST_BADPOS;
        end else begin
          ctrl.edit.kind = bol_pkg::EK_DEL;
          ctrl.edit.idx  = bol_pkg::IDX_W'(position - 1'b1);
          ctrl.len_nxt   = len_dec;
        end
      end
      // Unused codes leave the list as it is and report ok.
      default: ctrl.status = bol_pkg::ST_OK;
    endcase
  end

endmodule

/* src/bounded_ordered_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list: ordered list of up to CAPACITY words
// A row of word cells edited in place by front, back and positional inserts
// and deletes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one edit per beat: op, a 1-based position and a value.
//   out_ch returns one result per edit: status, the removed word, the front
//   and back words and the count after the edit.
//   The result beat is valid in the cycle after the edit beat is taken.
//   Every cell of the chain shifts in the same cycle, so one edit per
//   cycle is sustained while the receiver keeps out_ch.ready high.
//   The result sits in an output register. A new edit is taken in the same
//   cycle the waiting result leaves; while the receiver stalls, in_ch.ready
//   stays low and the list is not changed.
//   Reset empties the list at once (count is zero); no clearing pass runs,
//   as cells beyond the count are never reported.
// ----------------------------------------------------------------------------
module bounded_ordered_list (
  input  logic            clk,
  input  logic            rst_n,
  bol_in_if.sink          in_ch,
  bol_out_if.source       out_ch
);

  localparam int N = bol_pkg::CAPACITY;

  bol_pkg::cnt_t          length_r;
  logic                   out_valid_r;
  bol_pkg::status_t       status_r;
  logic [bol_pkg::VAL_W-1:0] removed_r;
  logic [bol_pkg::VAL_W-1:0] removed_nxt;
  logic                   in_acc;
  bol_pkg::ctrl_t         ctrl;
  bol_pkg::word_t         new_word;
  bol_pkg::word_t         words [N];
  bol_pkg::cnt_t          last_cnt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign new_word    = bol_pkg::DATA_WIDTH'(unsigned'(in_ch.value));

  bol_ctrl u_ctrl (
    .op       (in_ch.op),
    .position (in_ch.position),
    .length   (length_r),
    .ctrl     (ctrl)
  );

  // Chain of cells; the ends see zero beyond the row.
  for (genvar i = 0; i < N; i++) begin : g_cell
    bol_pkg::word_t left_w;
    bol_pkg::word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    bol_cell u_cell (
      .clk        (clk),
      .edit_en    (in_acc),
      .edit       (ctrl.edit),
      .cell_idx   (bol_pkg::IDX_W'(i)),
      .new_word   (new_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i])
    );
  end

  // The word leaving the list on a delete.
  always_comb begin
    removed_nxt = '0;
    if (ctrl.edit.kind == bol_pkg::EK_DEL) begin
      removed_nxt = bol_pkg::report_word(words[ctrl.edit.idx]);
    end
  end

  // Length and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        length_r    <= ctrl.len_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r  <= ctrl.status;
      removed_r <= removed_nxt;
    end
  end

  // Front and back come from the cells, which hold the state after the edit.
  assign last_cnt = length_r - 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.removed_value = removed_r;
  assign out_ch.count         = bol_pkg::CNT_OUT_W'(length_r);
  assign out_ch.front_value   = (length_r == '0) ? '0 : bol_pkg::report_word(words[0]);
  assign out_ch.back_value    = (length_r == '0) ? '0 :
                                bol_pkg::report_word(words[last_cnt[bol_pkg::IDX_W-1:0]]);

  // The count never passes the capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(length_r) <= N)
    else $error("list length above capacity");

  // A refused edit leaves the length unchanged.
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ctrl.status != bol_pkg::ST_OK |=> length_r == $past(length_r))
    else $error("refused edit changed the length");

  // An insert grows the list by one word.
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ctrl.edit.kind == bol_pkg::EK_INS |=>
      length_r == bol_pkg::CNT_W'($past(length_r) + 1'b1))
    else $error("insert did not grow the list by one");

  // Only a delete reports a removed word.
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ctrl.edit.kind != bol_pkg::EK_DEL |=> out_ch.removed_value == '0)
    else $error("removed word reported without a delete");

endmodule

/* dv/bounded_ordered_list_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_test: self-checking bench for the bounded ordered list
// Edits go in over in_ch and each result beat on out_ch is compared with a
// prediction from a queue-based copy of the list. Directed edits cover empty,
// single-word and full lists and bad positions; then random traffic runs
// under three idling mixes, plus a long receiver stall that fills the block.
// ----------------------------------------------------------------------------
module bounded_ordered_list_test;

  // Op codes the block must ignore.
  localparam logic [bol_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [bol_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int END_PAUSE      = 4;

  typedef struct {
    logic [bol_pkg::ST_W-1:0]      status;
    logic [bol_pkg::VAL_W-1:0]     removed;
    logic [bol_pkg::VAL_W-1:0]     front;
    logic [bol_pkg::VAL_W-1:0]     back;
    logic [bol_pkg::CNT_OUT_W-1:0] count;
  } list_result_t;

  logic clk;
  logic rst_n;

  bol_in_if  in_ch ();
  bol_out_if out_ch ();

  bounded_ordered_list u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the list and the results still owed by the block.
  logic [bol_pkg::VAL_W-1:0] list_words[$];
  list_result_t              owed_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_left;
  int list_target;
  int error_count;
  int edits_sent;
  int results_checked;
  int full_rejects;
  int empty_rejects;
  int badpos_rejects;
  int longest_list;

  // Clock: 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Applies one edit to the shadow list and returns the result it must give.
  function automatic list_result_t apply_edit(input logic [bol_pkg::OP_W-1:0] op,
                                              input logic [bol_pkg::POS_W-1:0] pos,
                                              input logic [bol_pkg::VAL_W-1:0] val);
    int len;
    list_result_t res;
    len = list_words.size();
    res.status  = bol_pkg::ST_OK;
    res.removed = '0;
    if (op <= bol_pkg::OP_INS_AFTER) begin
      if (len >= bol_pkg::CAPACITY) begin
        res.status = bol_pkg::ST_FULL;
      end else if (len == 0 || op == bol_pkg::OP_INS_BACK) begin
        list_words.push_back(val);
      end else if (op == bol_pkg::OP_INS_FRONT) begin
        list_words.push_front(val);
      end else if (pos == 0 || pos > len) begin
        res.status = bol_pkg::ST_BADPOS;
      end else begin
        list_words.insert(pos, val);
      end
    end else if (op <= bol_pkg::OP_DEL_AT) begin
      if (len == 0) begin
        res.status = bol_pkg::ST_EMPTY;
      end else if (op == bol_pkg::OP_DEL_FRONT) begin
        res.removed = list_words.pop_front();
      end else if (op == bol_pkg::OP_DEL_BACK) begin
        res.removed = list_words.pop_back();
      end else if (pos == 0 || pos > len) begin
        res.status = bol_pkg::ST_BADPOS;
      end else begin
        res.removed = list_words[pos - 1];
        list_words.delete(pos - 1);
      end
    end
    len = list_words.size();
    res.front = (len > 0) ? list_words[0] : '0;
    res.back  = (len > 0) ? list_words[len - 1] : '0;
    res.count = bol_pkg::CNT_OUT_W'(len);
    case (res.status)
      bol_pkg::ST_FULL:   full_rejects++;
      bol_pkg::ST_EMPTY:  empty_rejects++;
      bol_pkg::ST_BADPOS: badpos_rejects++;
      default: ;
    endcase
    if (len > longest_list) longest_list = len;
    return res;
  endfunction

  // Offers one edit, with random idle cycles first, and waits for its beat.
  task automatic send_edit(input logic [bol_pkg::OP_W-1:0] op,
                           input logic [bol_pkg::POS_W-1:0] pos,
                           input logic [bol_pkg::VAL_W-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.position <= pos;
    in_ch.value    <= val;
    do @(posedge clk); while (!in_ch.ready);
    owed_results.push_back(apply_edit(op, pos, val));
    edits_sent++;
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed edits steering the length toward list_target, with
  // some noise and a few ignored op codes.
  task automatic pick_edit(output logic [bol_pkg::OP_W-1:0] op,
                           output logic [bol_pkg::POS_W-1:0] pos,
                           output logic [bol_pkg::VAL_W-1:0] val);
    int len;
    int r;
    bit grow;
    len = list_words.size();
    r   = $urandom_range(99);
    case ($urandom_range(15))
      0:       val = '0;
      1:       val = '1;
      2:       val = 32'h7FFF_FFFF;
      3:       val = 32'h8000_0000;
      default: val = $urandom;
    endcase
    if (r < 3) begin
      op  = r[0] ? OP_SPARE_7 : OP_SPARE_6;
      pos = bol_pkg::POS_W'($urandom_range(31));
    end else if (r < 15) begin
      op  = bol_pkg::OP_W'($urandom_range(bol_pkg::OP_DEL_AT));
      pos = bol_pkg::POS_W'($urandom_range(31));
    end else begin
      grow = (len < list_target) || (len == list_target && $urandom_range(1));
      case ($urandom_range(2))
        0:       op = grow ? bol_pkg::OP_INS_FRONT : bol_pkg::OP_DEL_FRONT;
        1:       op = grow ? bol_pkg::OP_INS_BACK  : bol_pkg::OP_DEL_BACK;
        default: op = grow ? bol_pkg::OP_INS_AFTER : bol_pkg::OP_DEL_AT;
      endcase
      pos = (len > 0) ? bol_pkg::POS_W'($urandom_range(len, 1)) :
                        bol_pkg::POS_W'($urandom_range(31));
    end
  endtask

  // Receiver: checks each result beat and drives ready with idling and holds.
  always @(posedge clk) begin : result_side
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result beat with nothing owed (status %0d count %0d)",
                 $time, out_ch.status, out_ch.count);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        if (out_ch.status !== want.status || out_ch.removed_value !== want.removed ||
            out_ch.front_value !== want.front || out_ch.back_value !== want.back ||
            out_ch.count !== want.count) begin
          $display("%0t: mismatch expected st=%0d rm=%h fr=%h bk=%h cnt=%0d",
                   $time, want.status, want.removed, want.front, want.back, want.count);
          $display("%0t:          actual   st=%0d rm=%h fr=%h bk=%h cnt=%0d",
                   $time, out_ch.status, out_ch.removed_value, out_ch.front_value,
                   out_ch.back_value, out_ch.count);
          error_count++;
        end
      end
    end
    if (recv_hold_left > 0) begin
      out_ch.ready   <= 1'b0;
      recv_hold_left <= recv_hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run after too many cycles without any beat.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no beat for %0d cycles, %0d results still owed",
             $time, WATCHDOG_LIMIT, owed_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // Edits on an empty and a short list, bad positions and ignored op codes.
  task automatic test_empty_and_short_list();
    send_edit(bol_pkg::OP_DEL_FRONT, 5'd0, 32'h0);
    send_edit(bol_pkg::OP_DEL_BACK, 5'd0, 32'h0);
    send_edit(bol_pkg::OP_DEL_AT, 5'd1, 32'h0);
    send_edit(bol_pkg::OP_DEL_AT, 5'd31, 32'h0);
    // An insert after into an empty list ignores its position.
    send_edit(bol_pkg::OP_INS_AFTER, 5'd0, 32'h7FFF_FFFF);
    send_edit(bol_pkg::OP_INS_AFTER, 5'd0, 32'h1234_5678);
    send_edit(bol_pkg::OP_INS_AFTER, 5'd2, 32'h1234_5678);
    // Position equal to the length appends at the back.
    send_edit(bol_pkg::OP_INS_AFTER, 5'd1, 32'h8000_0000);
    send_edit(bol_pkg::OP_INS_FRONT, 5'd0, 32'h0);
    send_edit(bol_pkg::OP_INS_BACK, 5'd0, 32'hFFFF_FFFF);
    send_edit(OP_SPARE_6, 5'd1, 32'hDEAD_BEEF);
    send_edit(OP_SPARE_7, 5'd31, 32'hFFFF_FFFF);
    send_edit(bol_pkg::OP_DEL_AT, 5'd0, 32'h0);
    send_edit(bol_pkg::OP_DEL_AT, 5'd5, 32'h0);
    send_edit(bol_pkg::OP_DEL_AT, 5'd2, 32'hFFFF_FFFF);
    send_edit(bol_pkg::OP_DEL_FRONT, 5'd7, 32'h0);
    send_edit(bol_pkg::OP_DEL_BACK, 5'd0, 32'h0);
    // Delete at the only position empties the list.
    send_edit(bol_pkg::OP_DEL_AT, 5'd1, 32'h0);
    send_edit(bol_pkg::OP_INS_FRONT, 5'd31, 32'h0000_0001);
    send_edit(bol_pkg::OP_DEL_BACK, 5'd0, 32'h0);
    send_edit(bol_pkg::OP_INS_BACK, 5'd16, 32'h5555_5555);
    send_edit(bol_pkg::OP_DEL_AT, 5'd1, 32'h0);
  endtask

  // Fills the list, probes every insert when full and the top positions,
  // then drains it past empty.
  task automatic test_capacity_limits();
    while (list_words.size() < bol_pkg::CAPACITY) begin
      send_edit(bol_pkg::OP_INS_AFTER,
                bol_pkg::POS_W'($urandom_range(list_words.size(), 1)), $urandom);
    end
    send_edit(bol_pkg::OP_INS_FRONT, 5'd0, 32'hAAAA_AAAA);
    send_edit(bol_pkg::OP_INS_BACK, 5'd0, 32'hAAAA_AAAA);
    send_edit(bol_pkg::OP_INS_AFTER, bol_pkg::POS_W'(bol_pkg::CAPACITY), 32'hAAAA_AAAA);
    send_edit(bol_pkg::OP_DEL_AT, bol_pkg::POS_W'(bol_pkg::CAPACITY + 1), 32'h0);
    send_edit(bol_pkg::OP_DEL_AT, 5'd31, 32'h0);
    send_edit(bol_pkg::OP_DEL_AT, bol_pkg::POS_W'(bol_pkg::CAPACITY), 32'h0);
    send_edit(bol_pkg::OP_INS_AFTER, bol_pkg::POS_W'(bol_pkg::CAPACITY - 1), 32'h8000_0000);
    while (list_words.size() > 0) send_edit(bol_pkg::OP_DEL_BACK, 5'd0, 32'h0);
    send_edit(bol_pkg::OP_DEL_FRONT, 5'd0, 32'h0);
  endtask

  // The receiver holds off for a long stretch while edits keep coming, so
  // the block fills and stalls its input; then the sender waits for all.
  task automatic test_backpressure();
    logic [bol_pkg::OP_W-1:0]  op;
    logic [bol_pkg::POS_W-1:0] pos;
    logic [bol_pkg::VAL_W-1:0] val;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    list_target    = bol_pkg::CAPACITY / 2;
    recv_hold_left <= HOLD_CYCLES;
    repeat (30) begin
      pick_edit(op, pos, val);
      send_edit(op, pos, val);
    end
    wait_results_drained();
  endtask

  // Random traffic under one idling mix; ignored op codes do not count.
  task automatic test_random_traffic(input int n_edits, input int tx_idle, input int rx_idle);
    logic [bol_pkg::OP_W-1:0]  op;
    logic [bol_pkg::POS_W-1:0] pos;
    logic [bol_pkg::VAL_W-1:0] val;
    int done;
    int since_target;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    done = 0;
    since_target = 0;
    while (done < n_edits) begin
      if (since_target == 0) begin
        case ($urandom_range(3))
          0:       list_target = 0;
          1:       list_target = bol_pkg::CAPACITY;
          default: list_target = $urandom_range(bol_pkg::CAPACITY);
        endcase
        since_target = 24;
      end
      since_target--;
      pick_edit(op, pos, val);
      send_edit(op, pos, val);
      if (op <= bol_pkg::OP_DEL_AT) done++;
    end
    wait_results_drained();
  endtask

  // Test sequence.
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = '0;
    in_ch.position = '0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 33;
    recv_idle_pct  = 75;
    recv_hold_left = 0;
    list_target    = 0;
    error_count    = 0;
    edits_sent     = 0;
    results_checked = 0;
    full_rejects   = 0;
    empty_rejects  = 0;
    badpos_rejects = 0;
    longest_list   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_short_list();
    test_capacity_limits();
    wait_results_drained();
    test_backpressure();
    test_random_traffic(140, 33, 75);
    test_random_traffic(140, 75, 33);
    test_random_traffic(130, 0, 0);

    wait_results_drained();
    repeat (END_PAUSE) @(posedge clk);
    $display("Run covered %0d edits and %0d checked results; longest list %0d words.",
             edits_sent, results_checked, longest_list);
    $display("Rejected edits: %0d full, %0d empty, %0d bad position.",
             full_rejects, empty_rejects, badpos_rejects);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
src/bol_pkg.sv
src/bol_if.sv
src/bol_cell.sv
src/bol_ctrl.sv
src/bounded_ordered_list.sv
dv/bounded_ordered_list_test.sv
